>>> rtl/tba_pkg.sv
// Shared types and constants for the trade bar aggregator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package tba_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_INSTRUMENTS_DEF = 64;
  localparam int PRICE_BITS_DEF      = 32;

  // Fixed field widths of the request and result channels
  localparam int SLOT_W   = 6;
  localparam int TIME_W   = 32;
  localparam int PX_W     = 32;
  localparam int QTY_W    = 32;
  localparam int VOL_W    = 48;
  localparam int CNT_W    = 32;
  localparam int PERIOD_W = 12;

  // Bucket length after reset, in seconds
  localparam logic [PERIOD_W-1:0] BUCKET_SECONDS_RST = 12'd60;

  // Quotient bits retired per cycle by the modulo unit
  localparam int DIV_STEPS = 4;

  // Request operation codes
  localparam logic OP_TRADE = 1'b0;
  localparam logic OP_QUOTE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] instrument_index;
    logic [TIME_W-1:0] event_time;
    logic [PX_W-1:0]   trade_price;
    logic [QTY_W-1:0]  trade_quantity;
    logic [PX_W-1:0]   bid_price;
    logic [PX_W-1:0]   ask_price;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] bar_instrument;
    logic [TIME_W-1:0] bar_bucket_start;
    logic [PX_W-1:0]   open_px;
    logic [PX_W-1:0]   close_px;
    logic [PX_W-1:0]   high_px;
    logic [PX_W-1:0]   low_px;
    logic [VOL_W-1:0]  total_volume;
    logic [CNT_W-1:0]  trade_count;
    logic [PX_W-1:0]   last_bid;
    logic [PX_W-1:0]   last_ask;
    logic              last_of_run;
  } out_bar_t;

  // Strobes from the sequencer to the bar/quote store
  typedef struct packed {
    logic rd_en;
    logic bar_we;
    logic quote_we;
    logic clr_bars;
  } store_ctl_t;

endpackage

`default_nettype wire

>>> rtl/tba_div.sv
// Iterative modulo unit: bucket start = time - (time mod period).
// Uses tba_pkg for widths and the number of bits retired per cycle.
`default_nettype none

module tba_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tba_pkg::TIME_W-1:0]    dividend,
  input  logic [tba_pkg::PERIOD_W-1:0]  divisor,
  output logic                          done,
  output logic [tba_pkg::TIME_W-1:0]    bucket
);
  import tba_pkg::*;

  localparam int ITERS  = TIME_W / DIV_STEPS;
  localparam int ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1;

  logic                busy_r;
  logic                done_r;
  logic [ITER_W-1:0]   cnt_r;
  logic [TIME_W-1:0]   dvd_r;
  logic [TIME_W-1:0]   t_r;
  logic [PERIOD_W-1:0] dsr_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W-1:0] rem_step;
  logic [PERIOD_W:0]   trial;
  logic [TIME_W-1:0]   bucket_r;

  // Restoring division, DIV_STEPS dividend bits per cycle
  always_comb begin
    rem_step = rem_r;
    trial    = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_step, dvd_r[TIME_W-1-k]};
      if (trial >= {1'b0, dsr_r}) begin
        rem_step = PERIOD_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_step = trial[PERIOD_W-1:0];
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ITER_W'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      t_r   <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << DIV_STEPS;
      rem_r <= rem_step;
      if (cnt_r == ITER_W'(ITERS - 1)) begin
        bucket_r <= t_r - TIME_W'(rem_step);
      end
    end
  end

  assign done   = done_r;
  assign bucket = bucket_r;

endmodule

`default_nettype wire

>>> rtl/tba_store.sv
// Per-slot bar and quote memories with their occupancy bits.
// Uses tba_pkg for the store control strobes.
`default_nettype none

module tba_store #(
  parameter int NUM_SLOTS = tba_pkg::NUM_INSTRUMENTS_DEF,
  parameter int ADDR_W    = 6,
  parameter int BAR_W     = 64,
  parameter int QUOTE_W   = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tba_pkg::store_ctl_t      ctl,
  input  logic [ADDR_W-1:0]        rd_addr,
  input  logic [ADDR_W-1:0]        bar_wr_addr,
  input  logic [BAR_W-1:0]         bar_wr_data,
  input  logic [ADDR_W-1:0]        quote_wr_addr,
  input  logic [QUOTE_W-1:0]       quote_wr_data,
  output logic [BAR_W-1:0]         rd_bar,
  output logic [QUOTE_W-1:0]       rd_quote,
  output logic [NUM_SLOTS-1:0]     bar_present,
  output logic [NUM_SLOTS-1:0]     quote_present
);
  import tba_pkg::*;

  logic [BAR_W-1:0]     bar_mem   [NUM_SLOTS];
  logic [QUOTE_W-1:0]   quote_mem [NUM_SLOTS];
  logic [BAR_W-1:0]     rd_bar_r;
  logic [QUOTE_W-1:0]   rd_quote_r;
  logic [NUM_SLOTS-1:0] bar_present_r;
  logic [NUM_SLOTS-1:0] quote_present_r;

  // Bar memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctl.bar_we) begin
      bar_mem[bar_wr_addr] <= bar_wr_data;
    end
    if (ctl.rd_en) begin
      rd_bar_r <= bar_mem[rd_addr];
    end
  end

  // Quote memory, read alongside the bar
  always_ff @(posedge clk) begin
    if (ctl.quote_we) begin
      quote_mem[quote_wr_addr] <= quote_wr_data;
    end
    if (ctl.rd_en) begin
      rd_quote_r <= quote_mem[rd_addr];
    end
  end

  // Occupancy bits; a bulk clear drops all bars at a rollover
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_present_r   <= '0;
      quote_present_r <= '0;
    end else begin
      if (ctl.clr_bars) begin
        bar_present_r <= '0;
      end else if (ctl.bar_we) begin
        bar_present_r[bar_wr_addr] <= 1'b1;
      end
      if (ctl.quote_we) begin
        quote_present_r[quote_wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_bar        = rd_bar_r;
  assign rd_quote      = rd_quote_r;
  assign bar_present   = bar_present_r;
  assign quote_present = quote_present_r;

endmodule

`default_nettype wire

>>> rtl/trade_bar_aggregator.sv
// Trade bar aggregator top level: sequencer, config register, result register.
// Uses tba_pkg, tba_div (bucket modulo) and tba_store (bar/quote memories).
//
// Keeps an open/high/low/close bar per instrument slot for fixed time buckets
// whose length is set through the cfg port (0 acts as 1 second). Requests are
// handled one at a time. A quote update is written when it is accepted. A
// trade is accepted, runs the bucket modulo (4 bits per cycle over the 32-bit
// time) and then a read-modify-write of the slot's bar in memory. A trade
// that moves into a new bucket first walks the slot table: it steps over each
// empty slot below the highest occupied one, emits a bar for each occupied
// slot and then closes the run; the walk waits while the result side
// stalls. The result register lets the next request in while the last bar
// of a run still waits to be taken. Memories need no clearing pass;
// occupancy lives in flip-flops cleared by reset.
`default_nettype none

module trade_bar_aggregator #(
  parameter int NUM_INSTRUMENTS = tba_pkg::NUM_INSTRUMENTS_DEF,
  parameter int PRICE_BITS      = tba_pkg::PRICE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tba_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tba_pkg::out_bar_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tba_pkg::PERIOD_W-1:0]  cfg_data
);
  import tba_pkg::*;

  localparam int ADDR_W = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;

  typedef struct packed {
    logic [TIME_W-1:0]     first_time;
    logic [TIME_W-1:0]     last_time;
    logic [PRICE_BITS-1:0] open_px;
    logic [PRICE_BITS-1:0] close_px;
    logic [PRICE_BITS-1:0] high_px;
    logic [PRICE_BITS-1:0] low_px;
    logic [VOL_W-1:0]      volume;
    logic [CNT_W-1:0]      count;
    logic [PRICE_BITS-1:0] bid;
    logic [PRICE_BITS-1:0] ask;
  } bar_rec_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] bid;
    logic [PRICE_BITS-1:0] ask;
  } quote_rec_t;

  localparam int BAR_W   = $bits(bar_rec_t);
  localparam int QUOTE_W = $bits(quote_rec_t);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic                 bucket_valid_r, bucket_valid_nxt;
  logic [TIME_W-1:0]    cur_bucket_r, cur_bucket_nxt;
  logic [NUM_INSTRUMENTS-1:0] occ_sh_r, occ_sh_nxt;
  logic [ADDR_W-1:0]    scan_r, scan_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_bar_t             out_data_r, out_data_nxt;
  in_item_t             item_r;
  logic [PERIOD_W-1:0]  bucket_seconds_r;

  logic                 in_accept;
  logic                 in_range;
  logic                 out_free;
  logic [ADDR_W-1:0]    in_slot;
  logic [ADDR_W-1:0]    item_slot;
  logic [PRICE_BITS-1:0] in_bid, in_ask;
  logic [PRICE_BITS-1:0] item_px, item_bid, item_ask;
  logic                 item_px_nz;
  logic [PERIOD_W-1:0]  period;

  logic                 div_start;
  logic                 div_done;
  logic [TIME_W-1:0]    div_bucket;

  store_ctl_t           ctl;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    quote_wr_addr;
  quote_rec_t           quote_wr;
  logic [BAR_W-1:0]     rd_bar_vec;
  logic [QUOTE_W-1:0]   rd_quote_vec;
  bar_rec_t             rd_bar;
  quote_rec_t           rd_quote;
  bar_rec_t             upd;
  logic [VOL_W:0]       vsum;
  out_bar_t             emit_bar;
  logic [NUM_INSTRUMENTS-1:0] bar_present;
  logic [NUM_INSTRUMENTS-1:0] quote_present;

  // Request decode
  assign in_accept  = in_valid && !in_stall;
  assign in_range   = 32'(in_data.instrument_index) < NUM_INSTRUMENTS;
  assign in_slot    = in_data.instrument_index[ADDR_W-1:0];
  assign in_bid     = PRICE_BITS'(in_data.bid_price);
  assign in_ask     = PRICE_BITS'(in_data.ask_price);
  assign item_slot  = item_r.instrument_index[ADDR_W-1:0];
  assign item_px    = PRICE_BITS'(item_r.trade_price);
  assign item_bid   = PRICE_BITS'(item_r.bid_price);
  assign item_ask   = PRICE_BITS'(item_r.ask_price);
  assign item_px_nz = (item_px != '0);
  assign period     = (bucket_seconds_r == '0) ? PERIOD_W'(1) : bucket_seconds_r;
  assign out_free   = !out_valid_r || !out_stall;

  assign rd_bar   = bar_rec_t'(rd_bar_vec);
  assign rd_quote = quote_rec_t'(rd_quote_vec);

  // Bucket modulo unit
  tba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data.event_time),
    .divisor  (period),
    .done     (div_done),
    .bucket   (div_bucket)
  );

  // Bar and quote store
  tba_store #(
    .NUM_SLOTS (NUM_INSTRUMENTS),
    .ADDR_W    (ADDR_W),
    .BAR_W     (BAR_W),
    .QUOTE_W   (QUOTE_W)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .rd_addr       (rd_addr),
    .bar_wr_addr   (item_slot),
    .bar_wr_data   (upd),
    .quote_wr_addr (quote_wr_addr),
    .quote_wr_data (quote_wr),
    .rd_bar        (rd_bar_vec),
    .rd_quote      (rd_quote_vec),
    .bar_present   (bar_present),
    .quote_present (quote_present)
  );

  // Quote write: a quote update at accept time, or a trade at bar write-back
  always_comb begin
    if (state_r == S_WR) begin
      quote_wr_addr = item_slot;
      quote_wr.bid  = item_bid;
      quote_wr.ask  = item_ask;
    end else begin
      quote_wr_addr = in_slot;
      quote_wr.bid  = in_bid;
      quote_wr.ask  = in_ask;
    end
  end

  // Bar update for the trade being applied
  always_comb begin
    upd  = rd_bar;
    vsum = {1'b0, rd_bar.volume} + (VOL_W + 1)'(item_r.trade_quantity);
    if (!bar_present[item_slot]) begin
      upd.first_time = item_r.event_time;
      upd.last_time  = item_r.event_time;
      upd.open_px    = item_px;
      upd.close_px   = item_px;
      upd.high_px    = item_px;
      upd.low_px     = item_px;
      upd.volume     = VOL_W'(item_r.trade_quantity);
      upd.count      = CNT_W'(1);
      upd.bid        = item_bid;
      upd.ask        = item_ask;
    end else begin
      if (item_r.event_time < rd_bar.first_time) begin
        upd.first_time = item_r.event_time;
        upd.open_px    = item_px;
      end
      if (item_r.event_time > rd_bar.last_time) begin
        upd.last_time = item_r.event_time;
        upd.close_px  = item_px;
        upd.bid       = item_bid;
        upd.ask       = item_ask;
      end
      if (item_px > rd_bar.high_px) upd.high_px = item_px;
      if (item_px < rd_bar.low_px)  upd.low_px  = item_px;
      upd.volume = vsum[VOL_W] ? '1 : vsum[VOL_W-1:0];
      if (rd_bar.count != '1) upd.count = rd_bar.count + 1'b1;
    end
  end

  // Result for the slot under the scan pointer
  always_comb begin
    emit_bar.bar_instrument   = SLOT_W'(scan_r);
    emit_bar.bar_bucket_start = cur_bucket_r;
    emit_bar.last_of_run      = ((occ_sh_r >> 1) == '0);
    if (bar_present[scan_r]) begin
      emit_bar.open_px      = PX_W'(rd_bar.open_px);
      emit_bar.close_px     = PX_W'(rd_bar.close_px);
      emit_bar.high_px      = PX_W'(rd_bar.high_px);
      emit_bar.low_px       = PX_W'(rd_bar.low_px);
      emit_bar.total_volume = rd_bar.volume;
      emit_bar.trade_count  = rd_bar.count;
      emit_bar.last_bid     = PX_W'(rd_bar.bid);
      emit_bar.last_ask     = PX_W'(rd_bar.ask);
    end else begin
      emit_bar.open_px      = '0;
      emit_bar.close_px     = '0;
      emit_bar.high_px      = '0;
      emit_bar.low_px       = '0;
      emit_bar.total_volume = '0;
      emit_bar.trade_count  = '0;
      emit_bar.last_bid     = PX_W'(rd_quote.bid);
      emit_bar.last_ask     = PX_W'(rd_quote.ask);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    bucket_valid_nxt = bucket_valid_r;
    cur_bucket_nxt   = cur_bucket_r;
    occ_sh_nxt       = occ_sh_r;
    scan_nxt         = scan_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    ctl              = '0;
    rd_addr          = scan_r;
    div_start        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_range) begin
          if (in_data.operation == OP_QUOTE) begin
            ctl.quote_we = (in_bid != '0) && (in_ask != '0);
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (!bucket_valid_r || (div_bucket != cur_bucket_r)) begin
            occ_sh_nxt = bucket_valid_r ? (bar_present | quote_present) : '0;
            scan_nxt   = '0;
            state_nxt  = S_SCAN;
          end else begin
            state_nxt = item_px_nz ? S_RD : S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (occ_sh_r == '0) begin
          // run closed: drop bars, open the new bucket
          ctl.clr_bars     = 1'b1;
          bucket_valid_nxt = 1'b1;
          cur_bucket_nxt   = div_bucket;
          state_nxt        = item_px_nz ? S_RD : S_IDLE;
        end else if (occ_sh_r[0]) begin
          ctl.rd_en = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          occ_sh_nxt = occ_sh_r >> 1;
          scan_nxt   = scan_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = emit_bar;
          occ_sh_nxt    = occ_sh_r >> 1;
          scan_nxt      = scan_r + 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_RD: begin
        ctl.rd_en = 1'b1;
        rd_addr   = item_slot;
        state_nxt = S_WR;
      end
      S_WR: begin
        ctl.bar_we   = 1'b1;
        ctl.quote_we = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      bucket_valid_r   <= 1'b0;
      cur_bucket_r     <= '0;
      occ_sh_r         <= '0;
      scan_r           <= '0;
      out_valid_r      <= 1'b0;
      bucket_seconds_r <= BUCKET_SECONDS_RST;
    end else begin
      state_r        <= state_nxt;
      bucket_valid_r <= bucket_valid_nxt;
      cur_bucket_r   <= cur_bucket_nxt;
      occ_sh_r       <= occ_sh_nxt;
      scan_r         <= scan_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bucket_seconds_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
